// ----- src/life_grid_neighbor_census_core_macros.svh -----
// Assertion macros shared by the checker of the neighbour census core.
`ifndef LIFE_GRID_NEIGHBOR_CENSUS_CORE_MACROS_SVH
`define LIFE_GRID_NEIGHBOR_CENSUS_CORE_MACROS_SVH

// Implication in the same cycle, ignored while reset is high.
`define LGNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle, ignored while reset is high.
`define LGNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is sampled high.
`define LGNC_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/lgnc_pkg.sv -----
package lgnc_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int DIM_W      = 7;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_EDGES = 2'd2;

   typedef enum logic [1:0] {
      MODE_SET_LIVE = 2'd0,
      MODE_SET_DEAD = 2'd1,
      MODE_READ     = 2'd2,
      MODE_COUNT    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STEP_UP  = 2'd0,
      STEP_MID = 2'd1,
      STEP_DN  = 2'd2
   } step_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_EVAL = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
   } req_type;

   typedef struct packed {
      logic               alive;
      logic [CNT_W-1:0]   neighbor_count;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]   rows;
      logic [DIM_W-1:0]   cols;
      logic               wrap;
   } cfg_type;

   // Column taps and enables for one row word presented to the counting unit.
   typedef struct packed {
      logic [COL_W-1:0]   col_left;
      logic [COL_W-1:0]   col_mid;
      logic [COL_W-1:0]   col_right;
      logic               use_left;
      logic               use_mid;
      logic               use_right;
      logic               row_ok;
   } tap_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

// ----- src/lgnc_ram.sv -----
module lgnc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lgnc_row_count.sv -----
module lgnc_row_count (
   input  logic [lgnc_pkg::MAX_COLS-1:0] word,
   input  lgnc_pkg::tap_type             tap,
   output logic [1:0]                    sum
);

   logic bit_left;
   logic bit_mid;
   logic bit_right;

   assign bit_left  = tap.row_ok & tap.use_left  & word[tap.col_left];
   assign bit_mid   = tap.row_ok & tap.use_mid   & word[tap.col_mid];
   assign bit_right = tap.row_ok & tap.use_right & word[tap.col_right];

   assign sum = {1'b0, bit_left} + {1'b0, bit_mid} + {1'b0, bit_right};

endmodule

// ----- src/lgnc_ctrl.sv -----
module lgnc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  lgnc_pkg::cfg_type  cfg,
   input  logic               req_take,
   input  lgnc_pkg::req_type  req_item,
   output logic               busy,
   input  logic               out_free,
   output logic               res_valid,
   output lgnc_pkg::rsp_type  res_item
);

   lgnc_pkg::state_type state_ff, state_in;
   lgnc_pkg::step_type  step_ff, step_in;
   lgnc_pkg::mode_type  mode_ff, mode_in;

   logic [lgnc_pkg::ROW_W-1:0] row_ff, row_in, row_up_ff, row_up_in, row_dn_ff, row_dn_in;
   logic [lgnc_pkg::COL_W-1:0] col_ff, col_in, col_lf_ff, col_lf_in, col_rt_ff, col_rt_in;
   logic                       up_ok_ff, up_ok_in, dn_ok_ff, dn_ok_in;
   logic                       lf_ok_ff, lf_ok_in, rt_ok_ff, rt_ok_in;
   logic [lgnc_pkg::CNT_W-1:0] acc_ff, acc_in;
   logic                       alive_ff, alive_in, oor_ff, oor_in;

   logic [lgnc_pkg::MAX_ROWS-1:0] row_valid_ff;
   logic                          rd_valid_ff;

   logic [lgnc_pkg::ROW_W-1:0]    rd_addr;
   logic                          wr_en;
   logic [lgnc_pkg::MAX_COLS-1:0] wr_data;
   logic [lgnc_pkg::MAX_COLS-1:0] rd_data;
   logic [lgnc_pkg::MAX_COLS-1:0] word;
   logic [lgnc_pkg::MAX_COLS-1:0] col_mask;
   logic [1:0]                    row_sum;
   lgnc_pkg::tap_type             tap;

   logic [lgnc_pkg::DIM_W-1:0] req_row_x, req_col_x, row_p1, col_p1;
   logic                       req_oor, row_last, col_last;

   lgnc_ram #(
      .WIDTH (lgnc_pkg::MAX_COLS),
      .DEPTH (lgnc_pkg::MAX_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgnc_row_count u_row_count (
      .word (word),
      .tap  (tap),
      .sum  (row_sum)
   );

   // A row that has never been written since reset reads as all dead.
   assign word     = rd_valid_ff ? rd_data : '0;
   assign col_mask = lgnc_pkg::MAX_COLS'(1) << col_ff;

   always_comb begin
      tap.col_left  = col_lf_ff;
      tap.col_mid   = col_ff;
      tap.col_right = col_rt_ff;
      tap.use_left  = lf_ok_ff;
      tap.use_right = rt_ok_ff;
      tap.use_mid   = (step_ff != lgnc_pkg::STEP_MID);
      unique case (step_ff)
         lgnc_pkg::STEP_UP:  tap.row_ok = up_ok_ff;
         lgnc_pkg::STEP_MID: tap.row_ok = 1'b1;
         lgnc_pkg::STEP_DN:  tap.row_ok = dn_ok_ff;
         default:            tap.row_ok = 1'b0;
      endcase
   end

   // Neighbour coordinates, worked out while the item is taken.
   always_comb begin
      req_row_x = lgnc_pkg::DIM_W'(req_item.row);
      req_col_x = lgnc_pkg::DIM_W'(req_item.col);
      row_p1    = req_row_x + lgnc_pkg::DIM_W'(1);
      col_p1    = req_col_x + lgnc_pkg::DIM_W'(1);
      row_last  = (row_p1 >= cfg.rows);
      col_last  = (col_p1 >= cfg.cols);
      req_oor   = (req_row_x >= cfg.rows) || (req_col_x >= cfg.cols);
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      mode_in   = mode_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      row_up_in = row_up_ff;
      row_dn_in = row_dn_ff;
      col_lf_in = col_lf_ff;
      col_rt_in = col_rt_ff;
      up_ok_in  = up_ok_ff;
      dn_ok_in  = dn_ok_ff;
      lf_ok_in  = lf_ok_ff;
      rt_ok_in  = rt_ok_ff;
      acc_in    = acc_ff;
      alive_in  = alive_ff;
      oor_in    = oor_ff;
      rd_addr   = row_ff;
      wr_en     = 1'b0;
      wr_data   = word;

      unique case (state_ff)
         lgnc_pkg::ST_IDLE: begin
            if (req_take) begin
               mode_in   = req_item.mode;
               row_in    = req_item.row;
               col_in    = req_item.col;
               row_up_in = (req_item.row == '0) ?
                           lgnc_pkg::ROW_W'(cfg.rows - lgnc_pkg::DIM_W'(1)) :
                           req_item.row - lgnc_pkg::ROW_W'(1);
               col_lf_in = (req_item.col == '0) ?
                           lgnc_pkg::COL_W'(cfg.cols - lgnc_pkg::DIM_W'(1)) :
                           req_item.col - lgnc_pkg::COL_W'(1);
               row_dn_in = row_last ? '0 : row_p1[lgnc_pkg::ROW_W-1:0];
               col_rt_in = col_last ? '0 : col_p1[lgnc_pkg::COL_W-1:0];
               up_ok_in  = (req_item.row != '0) || cfg.wrap;
               lf_ok_in  = (req_item.col != '0) || cfg.wrap;
               dn_ok_in  = !row_last || cfg.wrap;
               rt_ok_in  = !col_last || cfg.wrap;
               acc_in    = '0;
               alive_in  = 1'b0;
               oor_in    = req_oor;
               state_in  = req_oor ? lgnc_pkg::ST_DONE : lgnc_pkg::ST_READ;
            end
         end
         lgnc_pkg::ST_READ: begin
            if (mode_ff == lgnc_pkg::MODE_COUNT) begin
               rd_addr = row_up_ff;
               step_in = lgnc_pkg::STEP_UP;
            end else begin
               rd_addr = row_ff;
               step_in = lgnc_pkg::STEP_MID;
            end
            state_in = lgnc_pkg::ST_EVAL;
         end
         lgnc_pkg::ST_EVAL: begin
            unique case (mode_ff)
               lgnc_pkg::MODE_SET_LIVE: begin
                  wr_en    = 1'b1;
                  wr_data  = word | col_mask;
                  alive_in = 1'b1;
                  state_in = lgnc_pkg::ST_DONE;
               end
               lgnc_pkg::MODE_SET_DEAD: begin
                  wr_en    = 1'b1;
                  wr_data  = word & ~col_mask;
                  alive_in = 1'b0;
                  state_in = lgnc_pkg::ST_DONE;
               end
               lgnc_pkg::MODE_READ: begin
                  alive_in = word[col_ff];
                  state_in = lgnc_pkg::ST_DONE;
               end
               lgnc_pkg::MODE_COUNT: begin
                  // The read of the next row goes out while this one is summed.
                  acc_in = acc_ff + lgnc_pkg::CNT_W'(row_sum);
                  unique case (step_ff)
                     lgnc_pkg::STEP_UP: begin
                        rd_addr = row_ff;
                        step_in = lgnc_pkg::STEP_MID;
                     end
                     lgnc_pkg::STEP_MID: begin
                        alive_in = word[col_ff];
                        rd_addr  = row_dn_ff;
                        step_in  = lgnc_pkg::STEP_DN;
                     end
                     default: begin
                        state_in = lgnc_pkg::ST_DONE;
                     end
                  endcase
               end
            endcase
         end
         lgnc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lgnc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgnc_pkg::ST_IDLE;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            row_valid_ff[row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      mode_ff     <= mode_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      row_up_ff   <= row_up_in;
      row_dn_ff   <= row_dn_in;
      col_lf_ff   <= col_lf_in;
      col_rt_ff   <= col_rt_in;
      up_ok_ff    <= up_ok_in;
      dn_ok_ff    <= dn_ok_in;
      lf_ok_ff    <= lf_ok_in;
      rt_ok_ff    <= rt_ok_in;
      acc_ff      <= acc_in;
      alive_ff    <= alive_in;
      oor_ff      <= oor_in;
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   assign busy      = (state_ff != lgnc_pkg::ST_IDLE);
   assign res_valid = (state_ff == lgnc_pkg::ST_DONE);

   always_comb begin
      res_item.alive          = alive_ff;
      res_item.neighbor_count = (mode_ff == lgnc_pkg::MODE_COUNT) ? acc_ff : '0;
      res_item.out_of_range   = oor_ff;
      if (oor_ff) begin
         res_item.alive          = 1'b0;
         res_item.neighbor_count = '0;
      end
   end

endmodule

// ----- src/life_grid_neighbor_census_core.sv -----
// Neighbour census over a 64 by 64 bit grid of cells, all dead after reset.
// Input channel req_: one beat carries a mode (set live, set dead, read, count),
// a row and a column. Result channel rsp_: exactly one beat per input beat, in
// order, with the cell state, the Moore neighbour count and an out-of-range flag.
// Both channels move a beat on a clock edge where valid is high and stall is low.
// The grid rows sit in a two-port memory with a registered read; one shared
// row-count unit sums the three taps of each row word as it comes out.
// A count reads three rows back to back; set, clear and read fetch one row, and an
// out-of-range beat fetches none. The result then passes from the done state into
// an output register. req_stall is high while an item is being worked on; the
// result waits in that output register, so the next item is taken while rsp_ is
// stalled, and that item then holds in its final state until the output register
// frees up. Configuration (grid_rows, grid_cols, wrap_edges at indices 0 to 2) is
// to be written by the user through csr_ only while the block is idle; the block
// does not enforce this, and csr_ready is always high.
// Synchronous reset marks every row as unwritten, so the grid reads as dead at
// once, restores a 64 by 64 bounded grid and empties the output register.
module life_grid_neighbor_census_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lgnc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lgnc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lgnc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lgnc_pkg::CSR_DATA_W-1:0]     csr_data
);

   lgnc_pkg::cfg_type cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lgnc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              busy;
   logic              out_free;
   logic              res_valid;
   logic              load;
   lgnc_pkg::rsp_type res_item;

   lgnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_take  (req_valid & ~busy),
      .req_item  (req_data),
      .busy      (busy),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   assign csr_ready = 1'b1;

   // Sizes are clamped into range as they are written.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lgnc_pkg::CSR_GRID_ROWS:
               cfg_in.rows = lgnc_pkg::clamp_dim(csr_data,
                                                 lgnc_pkg::DIM_W'(lgnc_pkg::MAX_ROWS));
            lgnc_pkg::CSR_GRID_COLS:
               cfg_in.cols = lgnc_pkg::clamp_dim(csr_data,
                                                 lgnc_pkg::DIM_W'(lgnc_pkg::MAX_COLS));
            lgnc_pkg::CSR_WRAP_EDGES:
               cfg_in.wrap = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load         = res_valid && out_free;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = load ? res_item : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows  <= lgnc_pkg::DIM_W'(lgnc_pkg::MAX_ROWS);
         cfg_ff.cols  <= lgnc_pkg::DIM_W'(lgnc_pkg::MAX_COLS);
         cfg_ff.wrap  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/lgnc_checker.sv -----
`include "life_grid_neighbor_census_core_macros.svh"

module lgnc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input lgnc_pkg::rsp_type               rsp_data
);

   // The block works on one item at a time, so it is busy right after a take.
   `LGNC_ASSERT_NEXT(a_busy_after_take, clock, reset,
      req_valid && !req_stall, req_stall,
      "block took a second item straight after the first")

   // A flagged coordinate never reports a live cell or a count.
   `LGNC_ASSERT_NOW(a_oor_zero, clock, reset,
      rsp_valid && rsp_data.out_of_range,
      !rsp_data.alive && (rsp_data.neighbor_count == '0),
      "out-of-range result carries data")

   // Eight neighbours at most.
   `LGNC_ASSERT_NOW(a_count_max, clock, reset,
      rsp_valid, rsp_data.neighbor_count <= lgnc_pkg::CNT_W'(8),
      "neighbour count above eight")

   `LGNC_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
      "stalled result beat changed")

   `LGNC_ASSERT_AFTER_RESET(a_reset_empty, clock, reset,
      !rsp_valid, "result pending after reset")

endmodule

bind life_grid_neighbor_census_core lgnc_checker u_lgnc_checker (.*);

// ----- dv/life_grid_neighbor_census_core_tb.sv -----
module life_grid_neighbor_census_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lgnc_pkg::*;

   localparam int NUM_PLANS = 12;
   localparam int RANDOM_PER_PLAN = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GRID_ROWS;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the grid and of the registers, as the block should hold them.
   logic [MAX_COLS-1:0]   grid_shadow [MAX_ROWS];
   logic [DIM_W-1:0]      shadow_rows = DIM_W'(64);
   logic [DIM_W-1:0]      shadow_cols = DIM_W'(64);
   logic                  shadow_wrap = 1'b0;

   req_type               req_backlog [$];
   rsp_type               census_due [$];
   logic                  no_idle = 1'b0;
   int                    fault_count = 0;
   int                    beats_checked = 0;
   int                    live_counts = 0;
   int                    range_flags = 0;

   int plan_rows [NUM_PLANS] = '{64, 64, 1, 2, 0, 127, 3, 2, 64, 5, 64, 64};
   int plan_cols [NUM_PLANS] = '{64, 64, 1, 2, 0, 127, 5, 64, 2, 3, 64, 64};
   int plan_wrap [NUM_PLANS] = '{0, 1, 1, 1, 0, 0, 1, 1, 0, 1, 1, 0};

   life_grid_neighbor_census_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int grid_span(input logic [DIM_W-1:0] value, input int limit);
      if (value == '0) begin
         return 1;
      end
      if (int'(value) > limit) begin
         return limit;
      end
      return int'(value);
   endfunction

   // Applies one beat to the shadow grid and returns the result it should give.
   function automatic rsp_type cell_census_next(input req_type beat);
      rsp_type res;
      int      nr, nc, r, c, rr, cc, dr, dc, total;
      res = '0;
      nr = grid_span(shadow_rows, MAX_ROWS);
      nc = grid_span(shadow_cols, MAX_COLS);
      r = int'(beat.row);
      c = int'(beat.col);
      if (r >= nr || c >= nc) begin
         res.out_of_range = 1'b1;
         return res;
      end
      case (beat.mode)
         MODE_SET_LIVE: begin
            grid_shadow[r][c] = 1'b1;
            res.alive = 1'b1;
         end
         MODE_SET_DEAD: begin
            grid_shadow[r][c] = 1'b0;
         end
         MODE_READ: begin
            res.alive = grid_shadow[r][c];
         end
         default: begin
            res.alive = grid_shadow[r][c];
            total = 0;
            // On a tiny torus the wrapped positions may repeat, the cell itself included.
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  if (dr == 0 && dc == 0) continue;
                  if (dr < 0) begin
                     if (r == 0) begin
                        if (!shadow_wrap) continue;
                        rr = nr - 1;
                     end else begin
                        rr = r - 1;
                     end
                  end else if (dr > 0) begin
                     if (r + 1 >= nr) begin
                        if (!shadow_wrap) continue;
                        rr = 0;
                     end else begin
                        rr = r + 1;
                     end
                  end else begin
                     rr = r;
                  end
                  if (dc < 0) begin
                     if (c == 0) begin
                        if (!shadow_wrap) continue;
                        cc = nc - 1;
                     end else begin
                        cc = c - 1;
                     end
                  end else if (dc > 0) begin
                     if (c + 1 >= nc) begin
                        if (!shadow_wrap) continue;
                        cc = 0;
                     end else begin
                        cc = c + 1;
                     end
                  end else begin
                     cc = c;
                  end
                  total += int'(grid_shadow[rr][cc]);
               end
            end
            res.neighbor_count = CNT_W'(total);
         end
      endcase
      return res;
   endfunction

   function automatic mode_type pick_mode();
      int v;
      v = $urandom_range(0, 99);
      if (v < 30) return MODE_SET_LIVE;
      if (v < 45) return MODE_SET_DEAD;
      if (v < 60) return MODE_READ;
      return MODE_COUNT;
   endfunction

   // Coordinates lean towards the edges and a small cluster so that counts are busy.
   function automatic logic [ROW_W-1:0] pick_coord(input int span, input int base);
      int v, pos;
      v = $urandom_range(0, 99);
      if (v < 15) begin
         pos = $urandom_range(0, 63);
      end else if (v < 40) begin
         case ($urandom_range(0, 3))
            0: pos = 0;
            1: pos = 1;
            2: pos = span - 2;
            default: pos = span - 1;
         endcase
         if (pos < 0) pos = 0;
      end else begin
         pos = base + $urandom_range(0, 4);
         if (pos > 63) pos = $urandom_range(0, 63);
      end
      return ROW_W'(pos);
   endfunction

   task automatic push_beat(input mode_type mode, input int row, input int col);
      req_type beat;
      beat.mode = mode;
      beat.row = ROW_W'(row);
      beat.col = COL_W'(col);
      req_backlog.push_back(beat);
   endtask

   // Waits until every queued beat has gone in and every result has come back.
   task automatic settle();
      while (req_backlog.size() != 0 || req_valid || census_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // Leaves csr_valid high so that back to back writes need no second assignment.
   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         CSR_GRID_ROWS: shadow_rows = DIM_W'(value);
         CSR_GRID_COLS: shadow_cols = DIM_W'(value);
         CSR_WRAP_EDGES: shadow_wrap = value[0];
         default: ;
      endcase
   endtask

   task automatic write_grid_cfg(input int rows, input int cols, input int wrap);
      csr_beat(CSR_GRID_ROWS, rows);
      csr_beat(CSR_GRID_COLS, cols);
      csr_beat(CSR_WRAP_EDGES, wrap);
      csr_valid <= 1'b0;
   endtask

   // Request driver: a stalled beat holds; otherwise the next beat or an idle cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            census_due.push_back(cell_census_next(req_data));
         end
         if (req_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= 15)) begin
            req_valid <= 1'b1;
            req_data <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and receiver-side stall.
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (census_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected result beat: alive=%0b count=%0d oor=%0b",
                           rsp_data.alive, rsp_data.neighbor_count,
                           rsp_data.out_of_range);
               end
            end else begin
               want = census_due.pop_front();
               beats_checked++;
               if (want.neighbor_count != '0) live_counts++;
               if (want.out_of_range) range_flags++;
               if (rsp_data.alive !== want.alive ||
                   rsp_data.neighbor_count !== want.neighbor_count ||
                   rsp_data.out_of_range !== want.out_of_range) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("mismatch on beat %0d: alive %0b/%0b count %0d/%0d oor %0b/%0b",
                              beats_checked, want.alive, rsp_data.alive,
                              want.neighbor_count, rsp_data.neighbor_count,
                              want.out_of_range, rsp_data.out_of_range);
                  end
               end
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 15);
      end
   end

   initial begin
      #(5_000_000);
      $display("life_grid_neighbor_census_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      int p, k, nr, nc, base_r, base_c;
      for (k = 0; k < MAX_ROWS; k++) begin
         grid_shadow[k] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners of the full bounded grid, then reads and counts around them.
      push_beat(MODE_SET_LIVE, 0, 0);
      push_beat(MODE_SET_LIVE, 0, 63);
      push_beat(MODE_SET_LIVE, 63, 0);
      push_beat(MODE_SET_LIVE, 63, 63);
      push_beat(MODE_SET_LIVE, 1, 1);
      push_beat(MODE_COUNT, 0, 0);
      push_beat(MODE_COUNT, 63, 63);
      push_beat(MODE_COUNT, 0, 1);
      push_beat(MODE_COUNT, 1, 0);
      push_beat(MODE_READ, 63, 63);
      push_beat(MODE_READ, 62, 62);
      push_beat(MODE_SET_DEAD, 63, 63);
      push_beat(MODE_READ, 63, 63);
      push_beat(MODE_COUNT, 62, 62);

      for (p = 0; p < NUM_PLANS; p++) begin
         if (p != 0) begin
            settle();
            write_grid_cfg(plan_rows[p], plan_cols[p], plan_wrap[p]);
         end
         no_idle = (p == 1);
         nr = grid_span(DIM_W'(plan_rows[p]), MAX_ROWS);
         nc = grid_span(DIM_W'(plan_cols[p]), MAX_COLS);
         if (p == 6) begin
            // Small torus: beats just past the edge are flagged and writes dropped.
            push_beat(MODE_COUNT, 3, 0);
            push_beat(MODE_SET_LIVE, 0, 5);
            push_beat(MODE_READ, 63, 63);
            push_beat(MODE_SET_LIVE, 2, 4);
            push_beat(MODE_COUNT, 0, 0);
            push_beat(MODE_COUNT, 2, 4);
         end
         base_r = $urandom_range(0, nr - 1);
         base_c = $urandom_range(0, nc - 1);
         for (k = 0; k < RANDOM_PER_PLAN; k++) begin
            push_beat(pick_mode(), int'(pick_coord(nr, base_r)),
                      int'(pick_coord(nc, base_c)));
         end
      end
      settle();
      no_idle = 1'b0;

      if (census_due.size() != 0) begin
         fault_count += census_due.size();
      end
      $display("census run: %0d result beats checked across %0d grid settings",
               beats_checked, NUM_PLANS);
      $display("census run: %0d nonzero neighbour counts, %0d out-of-range beats",
               live_counts, range_flags);
      if (fault_count == 0) begin
         $display("life_grid_neighbor_census_core regression: pass");
      end else begin
         $display("life_grid_neighbor_census_core regression: fail");
      end
      $finish;
   end

endmodule
